// ----- src/slasm_pkg.sv -----
// Shared types, codes and helpers of the serial receive line assembler.
package slasm_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Command codes from the front part to the back part.
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_BAD  = 2'd2;

    // Line terminators.
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // One input beat.
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [6:0] read_length;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [5:0] line_length;
        logic       last;
    } t_out_item;

    // A classified command; val holds the byte or the read length.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] val;
    } t_cmd;

    // True for carriage return or line feed.
    function automatic logic is_term(input logic [7:0] c);
        return (c == CHAR_CR) || (c == CHAR_LF);
    endfunction

endpackage

// ----- src/slasm_front.sv -----
// Front part: accepts input beats, classifies them and queues commands.
module slasm_front
    import slasm_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    logic [1:0] r_cnt, n_cnt;
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    t_cmd       r_q [2];
    t_cmd       w_cmd;
    logic       w_push;

    // Classify the incoming beat.
    always_comb begin
        if (i_in_item.mode) begin
            w_cmd.val = {1'b0, i_in_item.read_length};
            if (i_in_item.read_length == 7'd0 || i_in_item.read_length > 7'(LINE_MAX)) begin
                w_cmd.op = OP_BAD;
            end else begin
                w_cmd.op = OP_READ;
            end
        end else begin
            w_cmd.op  = OP_BYTE;
            w_cmd.val = i_in_item.rx_byte;
        end
    end

    // Two-entry command queue.
    assign o_in_stall  = (r_cnt == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_wr  = r_wr ^ w_push;
        n_rd  = r_rd ^ i_cmd_pop;
        n_cnt = r_cnt + 2'(w_push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_wr  <= n_wr;
            r_rd  <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

// ----- src/slasm_back.sv -----
// Back part: byte FIFO, line state and result sequencing.
module slasm_back
    import slasm_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ECHO  = 3'd1;
    localparam logic [2:0] S_LINE  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_ERR   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_active, n_active;
    logic [5:0]    r_stored, n_stored;
    logic [6:0]    r_size, n_size;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;
    t_cmd          r_cmd, n_cmd;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_mem [FIFO_DEPTH];
    logic          w_push;
    logic          w_can_emit;
    logic          w_room;
    logic          w_room_after;
    logic [5:0]    w_stored_inc;

    assign o_out_valid  = r_out_valid;
    assign o_out_item   = r_out;
    assign w_can_emit   = !r_out_valid || !i_out_stall;
    assign w_stored_inc = r_stored + 6'd1;
    // Room for one more byte now, and after storing one more.
    assign w_room       = ({1'b0, r_stored} + 7'd1) < r_size;
    assign w_room_after = ({1'b0, r_stored} + 7'd2) < r_size;

    // Sequencer: writes results into the output register; a new command is taken only in idle.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_active    = r_active;
        n_stored    = r_stored;
        n_size      = r_size;
        n_cmd       = r_cmd;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_push      = 1'b0;
        o_cmd_pop   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    case (i_cmd.op)
                        OP_BYTE: n_state = S_ECHO;
                        OP_READ: begin
                            n_size   = i_cmd.val[6:0];
                            n_stored = 6'd0;
                            n_active = 1'b1;
                            n_state  = S_DRAIN;
                        end
                        default: n_state = S_ERR;
                    endcase
                end
            end
            S_ECHO: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out       = '{KIND_ECHO, r_cmd.val, r_stored, !r_active};
                    if (r_active) begin
                        n_state = S_LINE;
                    end else begin
                        n_state = S_IDLE;
                        if (r_count < CW'(FIFO_DEPTH)) begin
                            w_push  = 1'b1;
                            n_head  = (r_head == PW'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                end
            end
            S_LINE: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    if (is_term(r_cmd.val)) begin
                        n_active = 1'b0;
                        n_out    = '{KIND_DONE, 8'd0, r_stored, 1'b1};
                        n_state  = S_IDLE;
                    end else begin
                        // An active line always has room for one more byte.
                        n_stored = w_stored_inc;
                        n_out    = '{KIND_DATA, r_cmd.val, w_stored_inc, w_room_after};
                        n_state  = w_room_after ? S_IDLE : S_DONE;
                    end
                end
            end
            S_DRAIN: begin
                if (w_room && r_count != '0) begin
                    n_state = S_FETCH;
                end else if (!w_room) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_tail      = (r_tail == PW'(FIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    n_count     = r_count - 1'b1;
                    if (is_term(r_rd_data)) begin
                        n_active = 1'b0;
                        n_out    = '{KIND_DONE, 8'd0, r_stored, 1'b1};
                        n_state  = S_IDLE;
                    end else begin
                        n_stored = w_stored_inc;
                        n_out    = '{KIND_DATA, r_rd_data, w_stored_inc,
                                     w_room_after && (r_count == CW'(1))};
                        n_state  = S_DRAIN;
                    end
                end
            end
            S_DONE: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_active    = 1'b0;
                    n_out       = '{KIND_DONE, 8'd0, r_stored, 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_ERR: begin
                if (w_can_emit) begin
                    n_out_valid = 1'b1;
                    n_out       = '{KIND_ERR, 8'd0, r_stored, 1'b1};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_active    <= 1'b0;
            r_stored    <= 6'd0;
            r_size      <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_active    <= n_active;
            r_stored    <= n_stored;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_cmd <= n_cmd;
    end

    // Byte FIFO memory with registered read at the tail.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_head] <= r_cmd.val;
        end
        r_rd_data <= r_mem[r_tail];
    end

endmodule

// ----- src/serial_receive_line_assembler.sv -----
// Top level of the serial receive line assembler.
//
//  Channel | Direction | Handshake                 | Beat
//  input   | in        | i_in_valid / o_in_stall   | i_in_item (byte or read request)
//  output  | out       | o_out_valid / i_out_stall | o_out_item (echo, data, done, error)
//
// A received byte gives an echo result and, in an open line, a data or completion result,
// then a completion result when the line fills. A read request drains FIFO bytes, each of
// which waits on the registered read port of the FIFO memory, and gives a completion result
// when the line fills or a terminator is drained. An error gives one error result.
// A two-entry command queue lets input beats be taken while the back part works.
// Reset is synchronous and clears pointers, counts and the line state; the FIFO
// memory is not cleared. A stalled output holds its beat and holds back the next result.
module serial_receive_line_assembler
    import slasm_pkg::*;
#(
    parameter int FIFO_DEPTH = 64,
    parameter int LINE_MAX   = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // Front: classification and command queue.
    slasm_front #(
        .LINE_MAX(LINE_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    // Back: FIFO, line state and results.
    slasm_back #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

endmodule

// ----- test/tb_slasm_score_pkg.sv -----
// Scoreboard class that predicts and checks the result beats of the line assembler.
package tb_slasm_score_pkg;
    import slasm_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int LINE_LIMIT = 64;

    // Tracks the receive ring and the open line, and holds the result beats still owed.
    class line_scoreboard;
        logic [7:0]  ring [RING_DEPTH];
        int unsigned ring_wr = 0;
        int unsigned ring_rd = 0;
        int unsigned ring_level = 0;
        bit          line_open = 1'b0;
        int unsigned line_fill = 0;
        int unsigned line_cap = 0;
        t_out_item   owed_q[$];
        t_out_item   step_q[$];
        int          errors = 0;

        function bit is_eol(logic [7:0] c);
            return (c == CHAR_CR) || (c == CHAR_LF);
        endfunction

        function void add_beat(logic [1:0] kind, logic [7:0] data, int unsigned fill);
            t_out_item b;
            b.kind        = kind;
            b.data        = data;
            b.line_length = 6'(fill);
            b.last        = 1'b0;
            step_q.push_back(b);
        endfunction

        // Works out every result beat caused by one accepted input beat.
        function void note_input(t_in_item it);
            logic [7:0]  c;
            int unsigned len;
            bit          ended;
            step_q.delete();
            if (it.mode == 1'b0) begin
                c = it.rx_byte;
                add_beat(KIND_ECHO, c, line_fill);
                if (line_open) begin
                    if (is_eol(c)) begin
                        line_open = 1'b0;
                        add_beat(KIND_DONE, 8'h00, line_fill);
                    end else begin
                        if (line_fill + 1 < line_cap) begin
                            line_fill++;
                            add_beat(KIND_DATA, c, line_fill);
                        end
                        if (line_fill + 1 >= line_cap) begin
                            line_open = 1'b0;
                            add_beat(KIND_DONE, 8'h00, line_fill);
                        end
                    end
                end else if (ring_level < RING_DEPTH) begin
                    // Idle bytes are buffered; a full ring drops them.
                    ring[ring_wr] = c;
                    ring_wr = (ring_wr + 1) % RING_DEPTH;
                    ring_level++;
                end
            end else begin
                len = it.read_length;
                if (len == 0 || len > LINE_LIMIT) begin
                    add_beat(KIND_ERR, 8'h00, line_fill);
                end else begin
                    // A valid request restarts the line and drains buffered bytes first.
                    ended     = 1'b0;
                    line_cap  = len;
                    line_fill = 0;
                    line_open = 1'b1;
                    while (!ended && line_fill + 1 < line_cap && ring_level > 0) begin
                        c = ring[ring_rd];
                        ring_rd = (ring_rd + 1) % RING_DEPTH;
                        ring_level--;
                        if (is_eol(c)) begin
                            line_open = 1'b0;
                            add_beat(KIND_DONE, 8'h00, line_fill);
                            ended = 1'b1;
                        end else begin
                            line_fill++;
                            add_beat(KIND_DATA, c, line_fill);
                        end
                    end
                    if (!ended && line_fill + 1 >= line_cap) begin
                        line_open = 1'b0;
                        add_beat(KIND_DONE, 8'h00, line_fill);
                    end
                end
            end
            if (step_q.size() > 0) begin
                step_q[step_q.size() - 1].last = 1'b1;
            end
            foreach (step_q[i]) begin
                owed_q.push_back(step_q[i]);
            end
        endfunction

        // Counts a failure and reports it.
        function void flag(string msg);
            errors++;
            $display("%s", msg);
        endfunction

        function void check_field(string name, int want, int got, realtime stamp);
            if (want != got) begin
                flag($sformatf("%0.1f ns: %s mismatch, expected %0d, actual %0d",
                               stamp, name, want, got));
            end
        endfunction

        // Compares one accepted result beat with the oldest one owed.
        function void check_result(t_out_item got, realtime stamp);
            t_out_item want;
            if (owed_q.size() == 0) begin
                flag($sformatf("%0.1f ns: unexpected result beat, expected none, actual %h",
                               stamp, got));
                return;
            end
            want = owed_q.pop_front();
            check_field("kind", want.kind, got.kind, stamp);
            check_field("data", want.data, got.data, stamp);
            check_field("line_length", want.line_length, got.line_length, stamp);
            check_field("last", want.last, got.last, stamp);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Any beat still owed at the end of the run is a failure.
        function void close_out(realtime stamp);
            if (owed_q.size() != 0) begin
                flag($sformatf("%0.1f ns: %0d result beats missing, expected next %h, actual none",
                               stamp, owed_q.size(), owed_q[0]));
                errors += owed_q.size() - 1;
            end
        endfunction
    endclass

endpackage

// ----- test/tb_serial_receive_line_assembler.sv -----
// Testbench for the serial receive line assembler: directed and random beats, checked in order.
module tb_serial_receive_line_assembler;
    timeunit 1ns;
    timeprecision 1ps;
    import slasm_pkg::*;
    import tb_slasm_score_pkg::*;

    localparam int LONG_HOLD   = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 300;
    localparam int ITEM_TARGET = 270;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    line_scoreboard board;
    int burst_left = 0;
    int sent_count = 0;
    int quiet_cycles = 0;
    bit hold_req = 1'b0;

    serial_receive_line_assembler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Beat builders; the field that the mode ignores still gets random bits.
    function automatic t_in_item mk_byte(logic [7:0] c);
        t_in_item it;
        it.mode        = 1'b0;
        it.rx_byte     = c;
        it.read_length = 7'($urandom_range(0, 127));
        return it;
    endfunction

    function automatic t_in_item mk_read(int len);
        t_in_item it;
        it.mode        = 1'b1;
        it.rx_byte     = 8'($urandom_range(0, 255));
        it.read_length = 7'(len);
        return it;
    endfunction

    function automatic logic [7:0] pick_char(int eol_pct);
        if ($urandom_range(0, 99) < eol_pct) begin
            return ($urandom_range(0, 1) == 0) ? CHAR_CR : CHAR_LF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CHAR_CR || c == CHAR_LF) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Offers one beat, in bursts with random gaps, and waits until it is taken.
    task automatic send_beat(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
    endtask

    // Stops offering beats until every owed result has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Extremes, error lengths, restarts and both terminators on a fresh block.
    task automatic run_directed();
        send_beat(mk_read(0));
        send_beat(mk_read(65));
        send_beat(mk_read(127));
        send_beat(mk_read(5));
        send_beat(mk_byte(8'h00));
        send_beat(mk_byte(8'hFF));
        send_beat(mk_read(0));
        send_beat(mk_byte(8'h41));
        send_beat(mk_byte(8'h55));
        send_beat(mk_byte(8'h41));
        send_beat(mk_byte(CHAR_CR));
        send_beat(mk_byte(8'h42));
        send_beat(mk_read(10));
        send_beat(mk_read(1));
        send_beat(mk_read(3));
        send_beat(mk_read(4));
        send_beat(mk_byte(CHAR_LF));
        send_beat(mk_read(2));
        send_beat(mk_byte(8'h7F));
        send_beat(mk_read(64));
        send_beat(mk_byte(8'h80));
        send_beat(mk_byte(CHAR_CR));
    endtask

    // Overfills the ring while idle, then drains it with two full-size reads.
    task automatic run_overflow();
        repeat (70) send_beat(mk_byte(pick_plain()));
        send_beat(mk_read(64));
        send_beat(mk_read(64));
    endtask

    // Mostly well-formed lines with random content, plus restarts, bad lengths and noise.
    task automatic run_random();
        int seq_no;
        int pick;
        int len;
        t_in_item junk;
        seq_no = 0;
        while (sent_count < ITEM_TARGET) begin
            seq_no++;
            if (seq_no == 6) begin
                hold_req = 1'b1;
                burst_left = 40;
            end
            if (seq_no == 18) begin
                settle();
            end
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                repeat ($urandom_range(0, 6)) send_beat(mk_byte(pick_char(8)));
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
                send_beat(mk_read(len));
                repeat ($urandom_range(0, 8)) send_beat(mk_byte(pick_char(15)));
            end else if (pick == 6) begin
                send_beat(mk_read($urandom_range(3, 20)));
                send_beat(mk_byte(pick_plain()));
                send_beat(mk_read($urandom_range(2, 10)));
            end else if (pick == 7) begin
                len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(65, 127);
                send_beat(mk_read(len));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    junk = t_in_item'(16'($urandom_range(0, 65535)));
                    send_beat(junk);
                end
            end
        end
    endtask

    // The receiver stalls on shifting patterns, with one long hold on request.
    initial begin
        int hold_left;
        int seg_left;
        int seg_style;
        int tick;
        hold_left = 0;
        seg_left  = 0;
        seg_style = 0;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_style = $urandom_range(0, 3);
                    seg_left  = $urandom_range(10, 120);
                end
                seg_left--;
                case (seg_style)
                    0: begin
                        i_out_stall <= 1'b0;
                    end
                    1: begin
                        i_out_stall <= ($urandom_range(0, 3) == 0);
                    end
                    2: begin
                        i_out_stall <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        i_out_stall <= (tick % 3 == 0);
                    end
                endcase
            end
        end
    end

    // Beat monitor on both channels, with a watchdog on cycles where nothing moves.
    always @(posedge i_clk) begin
        bit took;
        took = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                board.note_input(i_in_item);
                took = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_result(o_out_item, $realtime);
                took = 1'b1;
            end
            quiet_cycles = took ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0.1f ns: watchdog expired with %0d result beats owed",
                         $realtime, board.pending());
                $display("FAIL");
                $finish;
            end
        end
    end

    // Reset, stimulus phases, drain and the final verdict.
    initial begin
        board = new();
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_overflow();
        run_random();
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        board.close_out($realtime);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
